/* rtl/core/fm_ssg_note_command_register_writer_top_assert.svh */
// Assertion macros for the note command register writer.
`ifndef FM_SSG_NOTE_COMMAND_REGISTER_WRITER_TOP_ASSERT_SVH
`define FM_SSG_NOTE_COMMAND_REGISTER_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FSSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FSSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/fssg_pkg.sv */
// Shared types, command codes, register addresses and pitch tables.
package fssg_pkg;

  localparam logic [3:0] CMD_INIT       = 4'd0;
  localparam logic [3:0] CMD_NOTE_ON    = 4'd1;
  localparam logic [3:0] CMD_NOTE_OFF   = 4'd2;
  localparam logic [3:0] CMD_PITCH      = 4'd3;
  localparam logic [3:0] CMD_VOLUME     = 4'd4;
  localparam logic [3:0] CMD_ENVELOPE   = 4'd5;
  localparam logic [3:0] CMD_TONE_NOISE = 4'd6;
  localparam logic [3:0] CMD_TIMBRE     = 4'd7;
  localparam logic [3:0] CMD_OP_LEVEL   = 4'd8;

  localparam logic [7:0] ADDR_MIX       = 8'h07;
  localparam logic [7:0] ADDR_KEY       = 8'h28;
  localparam logic [7:0] ADDR_FNUM_HI   = 8'hA4;
  localparam logic [7:0] ADDR_FNUM_LO   = 8'hA0;
  localparam logic [7:0] ADDR_TL        = 8'h40;
  localparam logic [7:0] ADDR_VOL       = 8'h08;
  localparam logic [7:0] ADDR_ENV_SHAPE = 8'h0D;
  localparam logic [7:0] ADDR_ENV_LO    = 8'h0B;
  localparam logic [7:0] ADDR_ENV_HI    = 8'h0C;

  localparam logic [5:0] MIX_ALL_OFF    = 6'h3F;
  localparam logic [7:0] VOL_ENV_MODE   = 8'h10;
  localparam logic [3:0] SHAPE_HOLD_A   = 4'd9;
  localparam logic [3:0] SHAPE_HOLD_B   = 4'd15;
  localparam logic [3:0] KEY_MAX        = 4'd11;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [2:0]  channel;
    logic [2:0]  octave;
    logic [3:0]  note_key;
    logic [3:0]  level;
    logic [3:0]  env_shape;
    logic [15:0] env_period;
    logic [1:0]  mix_mode;
    logic [2:0]  algorithm;
    logic [3:0]  operator_mask;
    logic [1:0]  operator_index;
    logic [6:0]  total_level;
  } cmd_t;

  typedef struct packed {
    logic [5:0]            mixing_mask;
    logic [2:0][5:0]       voice_select;
    logic [2:0]            env_active;
    logic [3:0]            shape_held;
    logic [2:0]            timbre_present;
    logic [2:0][2:0]       timbre_alg;
    logic [2:0][3:0]       timbre_ops;
    logic [2:0][3:0][6:0]  op_levels;
  } state_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] addr;
    logic [3:0][7:0] data;
  } wr_burst_t;

  function automatic logic [10:0] fm_fnum(input logic [3:0] key);
    logic [10:0] v;
    case (key)
      4'd0:    v = 11'd617;
      4'd1:    v = 11'd654;
      4'd2:    v = 11'd693;
      4'd3:    v = 11'd734;
      4'd4:    v = 11'd778;
      4'd5:    v = 11'd824;
      4'd6:    v = 11'd873;
      4'd7:    v = 11'd925;
      4'd8:    v = 11'd980;
      4'd9:    v = 11'd1038;
      4'd10:   v = 11'd1100;
      4'd11:   v = 11'd1165;
      default: v = 11'd0;
    endcase
    return v;
  endfunction

  function automatic logic [12:0] ssg_period(input logic [3:0] key);
    logic [12:0] v;
    case (key)
      4'd0:    v = 13'd7645;
      4'd1:    v = 13'd7215;
      4'd2:    v = 13'd6810;
      4'd3:    v = 13'd6428;
      4'd4:    v = 13'd6067;
      4'd5:    v = 13'd5727;
      4'd6:    v = 13'd5405;
      4'd7:    v = 13'd5102;
      4'd8:    v = 13'd4816;
      4'd9:    v = 13'd4545;
      4'd10:   v = 13'd4290;
      4'd11:   v = 13'd4050;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

  // Register offset of operator 1..4 (index 0..3).
  function automatic logic [7:0] op_slot(input logic [1:0] opi);
    logic [7:0] v;
    case (opi)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h08;
      2'd2:    v = 8'h04;
      default: v = 8'h0C;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/fssg_decode.sv */
// Command decode: register write burst and next state for one command.
module fssg_decode (
  input  fssg_pkg::cmd_t    cmd,
  input  fssg_pkg::state_t  st,
  output fssg_pkg::wr_burst_t wr,
  output fssg_pkg::state_t  st_nxt
);
  import fssg_pkg::*;

  logic            is_fm;
  logic            is_ssg;
  logic [1:0]      f;
  logic [1:0]      s;
  logic [10:0]     fnum;
  logic [12:0]     p0;
  logic [12:0]     q;
  logic [12:0]     p_rnd;
  logic [12:0]     per;
  logic [2:0]      sh;
  logic [3:0]      inv_lvl;
  logic [5:0]      att;
  logic [3:0][6:0] row;
  logic [3:0][6:0] vol_tl;
  logic [2:0]      alg;
  logic [7:0]      tl_base;
  logic [5:0]      mm_on;
  logic [5:0]      mm_off;

  assign is_fm  = (cmd.channel <= 3'd2);
  assign is_ssg = (cmd.channel >= 3'd3) && (cmd.channel <= 3'd5);
  assign f      = is_fm ? cmd.channel[1:0] : 2'd0;
  assign s      = is_ssg ? 2'(cmd.channel - 3'd3) : 2'd0;

  assign fnum  = fm_fnum(cmd.note_key);
  assign p0    = ssg_period(cmd.note_key);
  assign sh    = cmd.octave - 3'd1;
  assign q     = p0 >> sh;
  assign p_rnd = {1'b0, q[12:1]} + {12'd0, q[0]};
  assign per   = (cmd.octave == 3'd0) ? p0 : p_rnd;

  assign inv_lvl = 4'd15 - cmd.level;
  assign att     = {1'b0, inv_lvl, 1'b0} + {2'b00, inv_lvl};
  assign row     = st.op_levels[f];
  assign alg     = st.timbre_alg[f];
  assign tl_base = ADDR_TL + {6'd0, f};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vol_tl[k] = row[k] + {1'b0, att};
    end
  end

  assign mm_on  = st.mixing_mask & ~st.voice_select[s];
  assign mm_off = st.mixing_mask | st.voice_select[s];

  always_comb begin
    wr     = '0;
    st_nxt = st;
    case (cmd.cmd)
      CMD_INIT: begin
        st_nxt.mixing_mask = MIX_ALL_OFF;
        wr.n       = 3'd1;
        wr.addr[0] = ADDR_MIX;
        wr.data[0] = {2'b00, MIX_ALL_OFF};
      end
      CMD_NOTE_ON: begin
        if (is_fm) begin
          if (st.timbre_present[f]) begin
            wr.n       = 3'd1;
            wr.addr[0] = ADDR_KEY;
            wr.data[0] = {st.timbre_ops[f], 2'b00, f};
          end
        end else if (is_ssg) begin
          st_nxt.mixing_mask = mm_on;
          wr.n       = 3'd1;
          wr.addr[0] = ADDR_MIX;
          wr.data[0] = {2'b00, mm_on};
          if (st.env_active[s] &&
              (st.shape_held == SHAPE_HOLD_A || st.shape_held == SHAPE_HOLD_B)) begin
            wr.n       = 3'd2;
            wr.addr[1] = ADDR_ENV_SHAPE;
            wr.data[1] = {4'd0, st.shape_held};
          end
        end
      end
      CMD_NOTE_OFF: begin
        if (is_fm) begin
          wr.n       = 3'd1;
          wr.addr[0] = ADDR_KEY;
          wr.data[0] = {6'd0, f};
        end else if (is_ssg) begin
          st_nxt.mixing_mask = mm_off;
          wr.n       = 3'd1;
          wr.addr[0] = ADDR_MIX;
          wr.data[0] = {2'b00, mm_off};
        end
      end
      CMD_PITCH: begin
        if (cmd.note_key <= KEY_MAX) begin
          if (is_fm) begin
            wr.n       = 3'd2;
            wr.addr[0] = ADDR_FNUM_HI + {6'd0, f};
            wr.data[0] = {2'b00, cmd.octave, fnum[10:8]};
            wr.addr[1] = ADDR_FNUM_LO + {6'd0, f};
            wr.data[1] = fnum[7:0];
          end else if (is_ssg) begin
            wr.n       = 3'd2;
            wr.addr[0] = {5'd0, s, 1'b0};
            wr.data[0] = per[7:0];
            wr.addr[1] = {5'd0, s, 1'b1};
            wr.data[1] = {4'd0, per[11:8]};
          end
        end
      end
      CMD_VOLUME: begin
        if (is_fm) begin
          if (st.timbre_present[f]) begin
            // carriers in order op4, op2, op3, op1
            wr.addr[0] = tl_base + op_slot(2'd3);
            wr.data[0] = {1'b0, vol_tl[3]};
            wr.addr[1] = tl_base + op_slot(2'd1);
            wr.data[1] = {1'b0, vol_tl[1]};
            wr.addr[2] = tl_base + op_slot(2'd2);
            wr.data[2] = {1'b0, vol_tl[2]};
            wr.addr[3] = tl_base + op_slot(2'd0);
            wr.data[3] = {1'b0, vol_tl[0]};
            wr.n = 3'd1 + {2'd0, alg >= 3'd4} + {2'd0, alg >= 3'd5}
                 + {2'd0, alg == 3'd7};
          end
        end else if (is_ssg) begin
          st_nxt.env_active[s] = 1'b0;
          wr.n       = 3'd1;
          wr.addr[0] = ADDR_VOL + {6'd0, s};
          wr.data[0] = {4'd0, cmd.level};
        end
      end
      CMD_ENVELOPE: begin
        if (is_ssg) begin
          st_nxt.env_active[s] = 1'b1;
          st_nxt.shape_held    = cmd.env_shape;
          wr.n       = 3'd4;
          wr.addr[0] = ADDR_VOL + {6'd0, s};
          wr.data[0] = VOL_ENV_MODE;
          wr.addr[1] = ADDR_ENV_SHAPE;
          wr.data[1] = {4'd0, cmd.env_shape};
          wr.addr[2] = ADDR_ENV_LO;
          wr.data[2] = cmd.env_period[7:0];
          wr.addr[3] = ADDR_ENV_HI;
          wr.data[3] = cmd.env_period[15:8];
        end
      end
      CMD_TONE_NOISE: begin
        if (is_ssg) begin
          case (cmd.mix_mode)
            2'd0:    st_nxt.voice_select[s] = 6'd1 << s;
            2'd1:    st_nxt.voice_select[s] = 6'd8 << s;
            2'd2:    st_nxt.voice_select[s] = 6'd9 << s;
            default: st_nxt.voice_select[s] = st.voice_select[s];
          endcase
        end
      end
      CMD_TIMBRE: begin
        if (is_fm) begin
          st_nxt.timbre_alg[f]     = cmd.algorithm;
          st_nxt.timbre_ops[f]     = cmd.operator_mask;
          st_nxt.timbre_present[f] = 1'b1;
        end
      end
      CMD_OP_LEVEL: begin
        if (is_fm) begin
          st_nxt.op_levels[f][cmd.operator_index] = cmd.total_level;
          wr.n       = 3'd1;
          wr.addr[0] = tl_base + op_slot(cmd.operator_index);
          wr.data[0] = {1'b0, cmd.total_level};
        end
      end
      default: begin
        wr = '0;
      end
    endcase
  end

endmodule

/* rtl/core/fm_ssg_note_command_register_writer_top.sv */
// Top level: music command in, sound chip register write words out.
//
//  channel  | direction | handshake            | word
//  in_      | input     | in_valid / in_ready   | one command
//  out_     | output    | out_valid / out_ready | one register write (addr, data)
//
// A command is held in an input register, decoded combinationally into a burst of
// zero to four writes, and loaded into a four-deep write shift register.
// Writes leave one per cycle while out_ready is high. The next command is taken
// while the current burst drains; it is decoded the cycle the last write of the
// burst is taken. Reset is synchronous, active low, and restores all channel
// state. Output stalls hold the burst and back up input.
module fm_ssg_note_command_register_writer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_cmd,
  input  logic [2:0]  in_channel,
  input  logic [2:0]  in_octave,
  input  logic [3:0]  in_note_key,
  input  logic [3:0]  in_level,
  input  logic [3:0]  in_env_shape,
  input  logic [15:0] in_env_period,
  input  logic [1:0]  in_mix_mode,
  input  logic [2:0]  in_algorithm,
  input  logic [3:0]  in_operator_mask,
  input  logic [1:0]  in_operator_index,
  input  logic [6:0]  in_total_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_reg_addr,
  output logic [7:0]  out_reg_data,
  output logic        out_last_write
);
  import fssg_pkg::*;

  cmd_t            in_r;
  logic            in_vld_r;
  state_t          st_r;
  state_t          st_nxt;
  wr_burst_t       wr;
  logic [3:0][7:0] addr_r;
  logic [3:0][7:0] data_r;
  logic [2:0]      cnt_r;
  logic            out_take;
  logic            buf_free;
  logic            advance;

  fssg_decode u_decode (
    .cmd    (in_r),
    .st     (st_r),
    .wr     (wr),
    .st_nxt (st_nxt)
  );

  assign out_valid      = (cnt_r != 3'd0);
  assign out_reg_addr   = addr_r[0];
  assign out_reg_data   = data_r[0];
  assign out_last_write = (cnt_r == 3'd1);
  assign out_take       = out_valid && out_ready;
  assign buf_free       = !out_valid || (out_take && out_last_write);
  assign advance        = in_vld_r && buf_free;
  assign in_ready       = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r                <= 1'b0;
      cnt_r                   <= 3'd0;
      st_r.mixing_mask        <= MIX_ALL_OFF;
      st_r.voice_select[0]    <= 6'd1;
      st_r.voice_select[1]    <= 6'd2;
      st_r.voice_select[2]    <= 6'd4;
      st_r.env_active         <= '0;
      st_r.shape_held         <= '0;
      st_r.timbre_present     <= '0;
      st_r.timbre_alg         <= '0;
      st_r.timbre_ops         <= '0;
      st_r.op_levels          <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
        in_r     <= '{cmd: in_cmd, channel: in_channel, octave: in_octave,
                      note_key: in_note_key, level: in_level,
                      env_shape: in_env_shape, env_period: in_env_period,
                      mix_mode: in_mix_mode, algorithm: in_algorithm,
                      operator_mask: in_operator_mask,
                      operator_index: in_operator_index,
                      total_level: in_total_level};
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end

      if (advance) begin
        st_r   <= st_nxt;
        cnt_r  <= wr.n;
        addr_r <= wr.addr;
        data_r <= wr.data;
      end else if (out_take) begin
        cnt_r  <= cnt_r - 3'd1;
        addr_r <= {8'h00, addr_r[3], addr_r[2], addr_r[1]};
        data_r <= {8'h00, data_r[3], data_r[2], data_r[1]};
      end
    end
  end

`include "fm_ssg_note_command_register_writer_top_assert.svh"

  `FSSG_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= 3'd4, "write count out of range")
  `FSSG_ASSERT_NEXT(a_burst_cont, out_take && !out_last_write, out_valid,
                    "burst ended before its last word")
  `FSSG_ASSERT_NEXT(a_in_held, in_valid && in_ready, in_vld_r,
                    "accepted command not held")

endmodule
